### rtl/button_ir_relay_controller_defines.svh
// ---------------------------------------------------------------------------
// button ir relay controller assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef BUTTON_IR_RELAY_CONTROLLER_DEFINES_SVH
`define BUTTON_IR_RELAY_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define BRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/brc_pkg.sv
// ---------------------------------------------------------------------------
// brc_pkg
// shared types, constants and helpers of the button ir relay controller
// ---------------------------------------------------------------------------
package brc_pkg;

    localparam int CHANNELS_DEF = 3;
    localparam int BTN_W        = 3;
    localparam int CODE_W       = 64;
    localparam int CNT_W        = 16;
    localparam int CLS_W        = 2;
    localparam int NEXT_W       = 2;
    localparam int CLS_OUT_W    = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // button classes
    typedef logic [CLS_W-1:0] cls_t;
    localparam cls_t CLS_IDLE     = 2'd0;
    localparam cls_t CLS_PRESSED  = 2'd1;
    localparam cls_t CLS_LONG     = 2'd2;
    localparam cls_t CLS_RELEASED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD      = 2'd3;

    // configuration reset values
    localparam logic [CNT_W-1:0] PRESS_TICKS_RST      = 16'd50;
    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 16'd1000;
    localparam logic [CNT_W-1:0] RELEASE_TICKS_RST    = 16'd50;
    localparam logic [CNT_W-1:0] POLL_PERIOD_RST      = 16'd300;

    typedef struct packed {
        logic [CNT_W-1:0] press_ticks;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] release_ticks;
        logic [CNT_W-1:0] poll_period;
    } cfg_t;

    typedef struct packed {
        logic [BTN_W-1:0]  button_low;
        logic              code_valid;
        logic [CODE_W-1:0] remote_code;
    } in_item_t;

    typedef struct packed {
        logic [BTN_W-1:0]     relay_on;
        logic                 learning;
        logic [NEXT_W-1:0]    learn_next;
        logic [CLS_OUT_W-1:0] button_classes;
    } out_item_t;

    // saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        sat_inc = (cnt == '1) ? cnt : cnt + 1'b1;
    endfunction

endpackage

### rtl/brc_if.sv
// ---------------------------------------------------------------------------
// brc channel interfaces
// valid/ready channels for input words and result words
// ---------------------------------------------------------------------------
interface brc_in_if;
    import brc_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brc_out_if;
    import brc_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/button_ir_relay_controller.sv
// ---------------------------------------------------------------------------
// button_ir_relay_controller
// relay control from debounced buttons and learned infrared remote codes
// ---------------------------------------------------------------------------
// The block takes one tick word per clock cycle while ready is high and returns
// exactly one result word for it. A word is first captured in an input register;
// when the result register is free or being read, the button trackers and the
// mode controller update all state at once and the result register is loaded,
// so a full word follows every cycle unless stalled. Ready drops only
// while both registers are full and the result word is not being taken.
// Configuration writes on cfg_wr_en take effect at once and are meant for an
// idle block.
`include "button_ir_relay_controller_defines.svh"

module button_ir_relay_controller
#(
    parameter int CHANNELS = brc_pkg::CHANNELS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    brc_in_if.sink                            item,
    brc_out_if.source                         result,
    input  logic                              cfg_wr_en,
    input  logic [brc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import brc_pkg::*;

    localparam int IDX_W   = $clog2(CHANNELS);
    localparam int PAD_W   = (CHANNELS > BTN_W) ? CHANNELS : BTN_W;
    localparam int IDX_P_W = (IDX_W > NEXT_W) ? IDX_W : NEXT_W;

    cfg_t                cfg_reg;
    logic                in_vld_reg;
    in_item_t            in_reg;
    logic                out_vld_reg;
    out_item_t           out_reg;
    out_item_t           out_next;
    logic                advance;
    logic                accept;
    logic [PAD_W-1:0]    btn_pad;
    cls_t [CHANNELS-1:0] cls_next;
    logic [CHANNELS-1:0] relay_next;
    logic                learning_next;
    logic [IDX_W-1:0]    learn_idx_next;
    logic [PAD_W-1:0]    relay_pad;
    logic [2*PAD_W-1:0]  cls_flat;
    logic [IDX_P_W-1:0]  idx_pad;

    // handshake
    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready   = !in_vld_reg || advance;
    assign accept       = item.valid && item.ready;
    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_ticks      <= PRESS_TICKS_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            cfg_reg.release_ticks    <= RELEASE_TICKS_RST;
            cfg_reg.poll_period      <= POLL_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PRESS_TICKS:      cfg_reg.press_ticks      <= cfg_data;
                REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_data;
                REG_RELEASE_TICKS:    cfg_reg.release_ticks    <= cfg_data;
                REG_POLL_PERIOD:      cfg_reg.poll_period      <= cfg_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item.data;
        end
    end

    // buttons beyond the input width read as released
    assign btn_pad = PAD_W'(in_reg.button_low);

    // per-button class trackers
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_btn
        brc_button u_button
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .low      (btn_pad[g]),
            .cfg      (cfg_reg),
            .cls_next (cls_next[g])
        );
    end

    // mode controller
    brc_core
    #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    )
    u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .code_valid     (in_reg.code_valid),
        .remote_code    (in_reg.remote_code),
        .poll_period    (cfg_reg.poll_period),
        .cls            (cls_next),
        .relay_next     (relay_next),
        .learning_next  (learning_next),
        .learn_idx_next (learn_idx_next)
    );

    // result word packing
    always_comb
    begin
        relay_pad = PAD_W'(relay_next);
        idx_pad   = IDX_P_W'(learn_idx_next);
        cls_flat  = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            cls_flat[2*i +: 2] = cls_next[i];
        end
        out_next.relay_on       = relay_pad[BTN_W-1:0];
        out_next.learning       = learning_next;
        out_next.learn_next     = idx_pad[NEXT_W-1:0];
        out_next.button_classes = cls_flat[CLS_OUT_W-1:0];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // checks
    `BRC_ASSERT_SAME(a_idle_index_zero,
        out_vld_reg && !out_reg.learning, out_reg.learn_next == '0,
        "learn index not zero in idle mode")
    `BRC_ASSERT_SAME(a_learn_relays_off,
        out_vld_reg && out_reg.learning && out_reg.learn_next != '0, out_reg.relay_on == '0,
        "relay on while learning past the first channel")
    `BRC_ASSERT_NEXT(a_accept_fills_input,
        accept, in_vld_reg,
        "accepted word not held in input register")
    `BRC_ASSERT_NEXT(a_stall_keeps_input,
        in_vld_reg && !advance, in_vld_reg && $stable(in_reg),
        "input register changed while stalled")

endmodule

### rtl/brc_button.sv
// ---------------------------------------------------------------------------
// brc_button
// per-button class tracker with saturating press and release counters
// ---------------------------------------------------------------------------
module brc_button
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          low,
    input  brc_pkg::cfg_t cfg,
    output brc_pkg::cls_t cls_next
);
    import brc_pkg::*;

    logic [CNT_W-1:0] press_cnt_reg;
    logic [CNT_W-1:0] press_cnt_next;
    logic [CNT_W-1:0] release_cnt_reg;
    logic [CNT_W-1:0] release_cnt_next;
    cls_t             cls_reg;
    logic [CNT_W-1:0] press_inc;
    logic [CNT_W-1:0] release_inc;

    assign press_inc   = sat_inc(press_cnt_reg);
    assign release_inc = sat_inc(release_cnt_reg);

    // class update for one tick
    always_comb
    begin
        press_cnt_next   = press_cnt_reg;
        release_cnt_next = release_cnt_reg;
        cls_next         = cls_reg;
        if (low)
        begin
            press_cnt_next = press_inc;
            if (press_inc > cfg.long_press_ticks)
            begin
                cls_next = CLS_LONG;
            end
            else if (press_inc > cfg.press_ticks)
            begin
                cls_next         = CLS_PRESSED;
                release_cnt_next = '0;
            end
        end
        else
        begin
            if (cls_reg == CLS_PRESSED || cls_reg == CLS_LONG)
            begin
                cls_next = CLS_RELEASED;
            end
            release_cnt_next = release_inc;
            if (release_inc > cfg.release_ticks)
            begin
                press_cnt_next = '0;
                cls_next       = CLS_IDLE;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_cnt_reg   <= '0;
            release_cnt_reg <= '0;
            cls_reg         <= CLS_IDLE;
        end
        else if (advance)
        begin
            press_cnt_reg   <= press_cnt_next;
            release_cnt_reg <= release_cnt_next;
            cls_reg         <= cls_next;
        end
    end

endmodule

### rtl/brc_core.sv
// ---------------------------------------------------------------------------
// brc_core
// idle and learn mode controller: relays, learned codes, held code, polling
// ---------------------------------------------------------------------------
module brc_core
#(
    parameter int CHANNELS = brc_pkg::CHANNELS_DEF,
    parameter int IDX_W    = $clog2(CHANNELS)
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             code_valid,
    input  logic [brc_pkg::CODE_W-1:0]       remote_code,
    input  logic [brc_pkg::CNT_W-1:0]        poll_period,
    input  brc_pkg::cls_t [CHANNELS-1:0]     cls,
    output logic [CHANNELS-1:0]              relay_next,
    output logic                             learning_next,
    output logic [IDX_W-1:0]                 learn_idx_next
);
    import brc_pkg::*;

    logic [CHANNELS-1:0] relay_reg;
    logic                learn_reg;
    logic [IDX_W-1:0]    learn_idx_reg;
    logic [CODE_W-1:0]   stored_reg [CHANNELS];
    logic [CODE_W-1:0]   stored_next [CHANNELS];
    cls_t                prev_reg [CHANNELS];
    cls_t                prev_next [CHANNELS];
    logic [CNT_W-1:0]    poll_reg;
    logic [CNT_W-1:0]    poll_next;
    logic                held_reg;
    logic                held_next;
    logic [CODE_W-1:0]   held_code_reg;
    logic [CODE_W-1:0]   held_code_next;
    logic [CNT_W-1:0]    poll_inc;

    assign poll_inc = poll_reg + 1'b1;

    // one tick of idle or learn mode
    always_comb
    begin
        relay_next     = relay_reg;
        learning_next  = learn_reg;
        learn_idx_next = learn_idx_reg;
        stored_next    = stored_reg;
        prev_next      = prev_reg;
        poll_next      = poll_reg;
        // a new code is latched only when none is held
        held_next      = held_reg | code_valid;
        held_code_next = held_reg ? held_code_reg : remote_code;
        if (learn_reg)
        begin
            if (learn_idx_reg == '0)
            begin
                relay_next = '0;
            end
            if (held_next)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (learn_idx_reg == IDX_W'(i))
                    begin
                        stored_next[i] = held_code_next;
                    end
                end
                held_next = 1'b0;
                if (learn_idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    learn_idx_next = '0;
                    learning_next  = 1'b0;
                end
                else
                begin
                    learn_idx_next = learn_idx_reg + 1'b1;
                end
            end
        end
        else
        begin
            // long press on buttons 0 and 1 enters learn mode
            if (cls[0] == CLS_LONG && cls[1] == CLS_LONG)
            begin
                learning_next = 1'b1;
            end
            if (poll_inc >= poll_period)
            begin
                // poll tick: consume the held code
                if (held_next)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (stored_reg[i] == held_code_next)
                        begin
                            relay_next[i] = ~relay_reg[i];
                        end
                    end
                    held_next = 1'b0;
                end
                poll_next = '0;
            end
            else
            begin
                // button edge from idle to pressed toggles its relay
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (cls[i] == CLS_PRESSED && prev_reg[i] == CLS_IDLE)
                    begin
                        relay_next[i] = ~relay_reg[i];
                    end
                    prev_next[i] = cls[i];
                end
                poll_next = poll_inc;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg     <= '0;
            learn_reg     <= 1'b0;
            learn_idx_reg <= '0;
            poll_reg      <= '0;
            held_reg      <= 1'b0;
            held_code_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                stored_reg[i] <= '0;
                prev_reg[i]   <= CLS_IDLE;
            end
        end
        else if (advance)
        begin
            relay_reg     <= relay_next;
            learn_reg     <= learning_next;
            learn_idx_reg <= learn_idx_next;
            poll_reg      <= poll_next;
            held_reg      <= held_next;
            held_code_reg <= held_code_next;
            stored_reg    <= stored_next;
            prev_reg      <= prev_next;
        end
    end

endmodule
